// ----- sv/usrng_pkg.sv -----
package usrng_pkg;

    // Input item: one half-microsecond tick
    typedef struct packed {
        logic start_request;
        logic echo_level;
    } item_t;

    // Result item: one per tick
    typedef struct packed {
        logic       pin_drive;
        logic       done_res;
        logic [9:0] distance_cm;
        logic [2:0] error_code;
        logic       busy_res;
    } result_t;

    // Measurement phases, one-hot
    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_TRIG = 4'b0010,
        PH_RISE = 4'b0100,
        PH_FALL = 4'b1000
    } phase_t;

    // Error codes
    typedef enum logic [2:0] {
        ERR_NONE    = 3'd0,
        ERR_BUSY    = 3'd1,
        ERR_TIMEOUT = 3'd2,
        ERR_EDGE    = 3'd3,
        ERR_RANGE   = 3'd4
    } err_t;

    // Per-item status carried from the controller to the distance stages
    typedef struct packed {
        logic pin_drive;
        logic done;
        err_t err;
        logic busy;
    } flags_t;

    // Configuration register indexes
    localparam logic [1:0] REG_TRIGGER  = 2'd0;
    localparam logic [1:0] REG_TIMEOUT  = 2'd1;
    localparam logic [1:0] REG_MIN_DIST = 2'd2;
    localparam logic [1:0] REG_MAX_DIST = 2'd3;

    // Configuration reset values
    localparam logic [15:0] TRIGGER_RESET  = 16'd10;
    localparam logic [15:0] TIMEOUT_RESET  = 16'd40000;
    localparam logic [9:0]  MIN_DIST_RESET = 10'd2;
    localparam logic [9:0]  MAX_DIST_RESET = 10'd300;

    // Echo ticks per centimeter after halving the round trip
    localparam logic [63:0] TICKS_PER_CM = 64'd58;

endpackage

// ----- sv/ultrasonic_single_pin_ranger.sv -----
// Single-pin ultrasonic ranger: one tick item in, one result item out.
// Three stages from item accept to result valid (controller register,
// reciprocal multiply register, range check / output register).
// Throughput: one item per cycle unless stalled; stages move independently.
// Reset (rst_n low, async): idle phase, count 0, pipeline empty,
// configuration back to trigger 10, timeout 40000, min 2 cm, max 300 cm.
module ultrasonic_single_pin_ranger #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  usrng_pkg::item_t     item,
    output logic                 result_valid,
    input  logic                 result_stall,
    output usrng_pkg::result_t   result,
    input  logic                 cfg_write,
    input  logic [1:0]           cfg_index,
    input  logic [15:0]          cfg_data
);
    import usrng_pkg::*;

    logic [15:0] trigger_reg, timeout_reg;
    logic [9:0]  min_reg, max_reg;
    logic        v1_reg, v2_reg, v3_reg;
    logic        en1, en2, en3;
    logic        accept;
    flags_t      flags1;
    logic [COUNT_WIDTH-2:0] half1;

    // Stage enables: a stage loads when it is empty or its contents move on
    assign en3        = !v3_reg || !result_stall;
    assign en2        = !v2_reg || en3;
    assign en1        = !v1_reg || en2;
    assign item_stall = !en1;
    assign accept     = item_valid && en1;
    assign result_valid = v3_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trigger_reg <= TRIGGER_RESET;
            timeout_reg <= TIMEOUT_RESET;
            min_reg     <= MIN_DIST_RESET;
            max_reg     <= MAX_DIST_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_TRIGGER:  trigger_reg <= cfg_data;
                REG_TIMEOUT:  timeout_reg <= cfg_data;
                REG_MIN_DIST: min_reg     <= cfg_data[9:0];
                REG_MAX_DIST: max_reg     <= cfg_data[9:0];
                default:      ;
            endcase
        end
    end

    // Stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= item_valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    usrng_ctrl #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (accept),
        .item          (item),
        .trigger_ticks (trigger_reg),
        .timeout_ticks (timeout_reg),
        .flags         (flags1),
        .half_count    (half1)
    );

    usrng_dist #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dist (
        .clk          (clk),
        .load_mul     (en2),
        .load_out     (en3),
        .flags        (flags1),
        .half_count   (half1),
        .min_distance (min_reg),
        .max_distance (max_reg),
        .result       (result)
    );

    // A completed measurement reports either success or out of range
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.done_res |->
            (result.error_code == ERR_NONE || result.error_code == ERR_RANGE))
        else $error("done item with unexpected error code");

    // A nonzero distance only comes with a clean completed measurement
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.distance_cm != 10'd0) |->
            result.done_res && (result.error_code == ERR_NONE))
        else $error("distance reported without a good measurement");

    // Driving the trigger means a measurement is in progress
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.pin_drive |-> result.busy_res)
        else $error("pin driven while not busy");

    // Input stalls only when every stage is full and the output is held
    assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> v1_reg && v2_reg && result_valid && result_stall)
        else $error("input stalled with room in the pipeline");

endmodule

// ----- sv/usrng_ctrl.sv -----
module usrng_ctrl #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      step,
    input  usrng_pkg::item_t          item,
    input  logic [15:0]               trigger_ticks,
    input  logic [15:0]               timeout_ticks,
    output usrng_pkg::flags_t         flags,
    output logic [COUNT_WIDTH-2:0]    half_count
);
    import usrng_pkg::*;

    localparam int CW = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    phase_t                 phase_reg, phase_next;
    logic [COUNT_WIDTH-1:0] tick_reg, tick_next;
    logic                   echo_prev_reg;
    logic [COUNT_WIDTH-1:0] cnt_inc;
    logic [CW-1:0]          cnt_ext, trig_ext, tmo_ext;
    logic                   rise, fall;
    logic                   done;
    err_t                   err;

    flags_t                 flags_reg;
    logic [COUNT_WIDTH-2:0] half_reg;

    assign rise    = !echo_prev_reg && item.echo_level;
    assign fall    = echo_prev_reg && !item.echo_level;
    // saturating count
    assign cnt_inc  = (tick_reg == COUNT_MAX) ? tick_reg : tick_reg + 1'b1;
    assign cnt_ext  = CW'(cnt_inc);
    assign trig_ext = CW'(trigger_ticks);
    assign tmo_ext  = CW'(timeout_ticks);

    // Phase and counter update for one tick
    always_comb
    begin
        phase_next = phase_reg;
        tick_next  = tick_reg;
        err        = ERR_NONE;
        done       = 1'b0;
        if (phase_reg != PH_IDLE && item.start_request)
        begin
            err        = ERR_BUSY;
            phase_next = PH_IDLE;
            tick_next  = '0;
        end
        else
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    if (rise)
                    begin
                        err = ERR_EDGE;
                    end
                    else if (item.start_request)
                    begin
                        phase_next = PH_TRIG;
                        tick_next  = '0;
                    end
                end
                PH_TRIG:
                begin
                    tick_next = cnt_inc;
                    if (cnt_ext >= trig_ext)
                    begin
                        phase_next = PH_RISE;
                        tick_next  = '0;
                    end
                end
                PH_RISE:
                begin
                    if (rise)
                    begin
                        phase_next = PH_FALL;
                        tick_next  = '0;
                    end
                    else
                    begin
                        tick_next = cnt_inc;
                        if (cnt_ext >= tmo_ext)
                        begin
                            err        = ERR_TIMEOUT;
                            phase_next = PH_IDLE;
                            tick_next  = '0;
                        end
                    end
                end
                PH_FALL:
                begin
                    if (fall)
                    begin
                        done       = 1'b1;
                        phase_next = PH_IDLE;
                        tick_next  = '0;
                    end
                    else
                    begin
                        tick_next = cnt_inc;
                        if (cnt_ext >= tmo_ext)
                        begin
                            err        = ERR_TIMEOUT;
                            phase_next = PH_IDLE;
                            tick_next  = '0;
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                    tick_next  = '0;
                end
            endcase
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            tick_reg      <= '0;
            echo_prev_reg <= 1'b0;
        end
        else if (step)
        begin
            phase_reg     <= phase_next;
            tick_reg      <= tick_next;
            echo_prev_reg <= item.echo_level;
        end
    end

    // Stage 1 payload: status and halved echo count
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            flags_reg.pin_drive <= (phase_next == PH_TRIG);
            flags_reg.done      <= done;
            flags_reg.err       <= err;
            flags_reg.busy      <= (phase_next != PH_IDLE);
            half_reg            <= tick_reg[COUNT_WIDTH-1:1];
        end
    end

    assign flags      = flags_reg;
    assign half_count = half_reg;

endmodule

// ----- sv/usrng_dist.sv -----
module usrng_dist #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                      clk,
    input  logic                      load_mul,
    input  logic                      load_out,
    input  usrng_pkg::flags_t         flags,
    input  logic [COUNT_WIDTH-2:0]    half_count,
    input  logic [9:0]                min_distance,
    input  logic [9:0]                max_distance,
    output usrng_pkg::result_t        result
);
    import usrng_pkg::*;

    // floor(h / 58) = (h * M) >> SHIFT, exact for h below 2^(COUNT_WIDTH-1)
    localparam int SHIFT = COUNT_WIDTH + 5;
    localparam int PW    = 2 * COUNT_WIDTH;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << SHIFT) + TICKS_PER_CM - 64'd1) / TICKS_PER_CM;
    localparam logic [COUNT_WIDTH-1:0] RECIP_M = RECIP_FULL[COUNT_WIDTH-1:0];
    localparam int DW   = PW - SHIFT;
    localparam int CMPW = (DW > 10) ? DW : 10;

    flags_t         flags_reg;
    logic [PW-1:0]  prod_reg;
    result_t        result_reg;
    logic [DW-1:0]  dist_cm;
    logic [CMPW-1:0] dist_ext, min_ext, max_ext;
    logic           in_range;

    // Stage 2: reciprocal multiply
    always_ff @(posedge clk)
    begin
        if (load_mul)
        begin
            flags_reg <= flags;
            prod_reg  <= PW'(half_count) * PW'(RECIP_M);
        end
    end

    assign dist_cm  = prod_reg[PW-1:SHIFT];
    assign dist_ext = CMPW'(dist_cm);
    assign min_ext  = CMPW'(min_distance);
    assign max_ext  = CMPW'(max_distance);
    assign in_range = (dist_ext >= min_ext) && (dist_ext <= max_ext);

    // Stage 3: range check and result register
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            result_reg.pin_drive <= flags_reg.pin_drive;
            result_reg.done_res  <= flags_reg.done;
            result_reg.busy_res  <= flags_reg.busy;
            if (flags_reg.done && in_range)
            begin
                result_reg.distance_cm <= dist_ext[9:0];
                result_reg.error_code  <= ERR_NONE;
            end
            else if (flags_reg.done)
            begin
                result_reg.distance_cm <= '0;
                result_reg.error_code  <= ERR_RANGE;
            end
            else
            begin
                result_reg.distance_cm <= '0;
                result_reg.error_code  <= flags_reg.err;
            end
        end
    end

    assign result = result_reg;

endmodule

// ----- tb/tb_top.sv -----
module tb_top;
    import usrng_pkg::*;

    localparam int  MAX_SHOWN   = 10;
    localparam int  DRAIN_WAIT  = 8;
    localparam int  RANDOM_TICKS = 350;
    localparam int  QUIET_TICKS  = 150;
    localparam longint RUN_LIMIT = 64'd30_000_000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        item_valid = 1'b0;
    logic        item_stall;
    item_t       item = '0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    result_t     result;
    logic        cfg_write = 1'b0;
    logic [1:0]  cfg_index = REG_TRIGGER;
    logic [15:0] cfg_data = '0;

    // Shadow of the ranger state and its registers
    phase_t      cur_phase = PH_IDLE;
    logic [15:0] tick_cnt = '0;
    logic        echo_last = 1'b0;
    logic [15:0] trig_reg = TRIGGER_RESET;
    logic [15:0] tmo_reg = TIMEOUT_RESET;
    logic [9:0]  min_reg = MIN_DIST_RESET;
    logic [9:0]  max_reg = MAX_DIST_RESET;

    result_t     pending_results[$];
    int          fail_count = 0;
    int          ticks_sent = 0;
    bit          quiet = 1'b0;

    ultrasonic_single_pin_ranger dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // One tick of the ranger: advances the shadow state, returns the result item
    function automatic result_t compute_tick(item_t it);
        result_t    r;
        logic       rise;
        logic       fall;
        logic [15:0] dist_cm;
        r    = '0;
        rise = !echo_last && it.echo_level;
        fall = echo_last && !it.echo_level;
        r.error_code = ERR_NONE;
        if (cur_phase != PH_IDLE && it.start_request)
        begin
            r.error_code = ERR_BUSY;
            cur_phase    = PH_IDLE;
            tick_cnt     = '0;
        end
        else if (cur_phase == PH_IDLE)
        begin
            // a rising edge wins over a start on the same tick
            if (rise)
                r.error_code = ERR_EDGE;
            else if (it.start_request)
            begin
                cur_phase = PH_TRIG;
                tick_cnt  = '0;
            end
        end
        else if (cur_phase == PH_TRIG)
        begin
            if (tick_cnt != 16'hFFFF)
                tick_cnt++;
            if (tick_cnt >= trig_reg)
            begin
                cur_phase = PH_RISE;
                tick_cnt  = '0;
            end
        end
        else if (cur_phase == PH_RISE && rise)
        begin
            cur_phase = PH_FALL;
            tick_cnt  = '0;
        end
        else if (cur_phase == PH_FALL && fall)
        begin
            dist_cm = (tick_cnt / 2) / 16'(TICKS_PER_CM);
            r.done_res = 1'b1;
            if (dist_cm >= {6'd0, min_reg} && dist_cm <= {6'd0, max_reg})
                r.distance_cm = dist_cm[9:0];
            else
                r.error_code = ERR_RANGE;
            cur_phase = PH_IDLE;
            tick_cnt  = '0;
        end
        else
        begin
            // waiting on an echo edge
            if (tick_cnt != 16'hFFFF)
                tick_cnt++;
            if (tick_cnt >= tmo_reg)
            begin
                r.error_code = ERR_TIMEOUT;
                cur_phase    = PH_IDLE;
                tick_cnt     = '0;
            end
        end
        echo_last   = it.echo_level;
        r.pin_drive = (cur_phase == PH_TRIG);
        r.busy_res  = (cur_phase != PH_IDLE);
        return r;
    endfunction

    // Receiver stall pattern
    always @(posedge clk)
    begin
        if (!rst_n || quiet)
            result_stall <= 1'b0;
        else
            result_stall <= ($urandom_range(0, 99) < 24);
    end

    // Result checker
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_results.size() == 0)
            begin
                fail_count++;
                if (fail_count <= MAX_SHOWN)
                    $display("unexpected result item: %p", result);
            end
            else
            begin
                want = pending_results.pop_front();
                if (result.pin_drive !== want.pin_drive
                    || result.done_res !== want.done_res
                    || result.distance_cm !== want.distance_cm
                    || result.error_code !== want.error_code
                    || result.busy_res !== want.busy_res)
                begin
                    fail_count++;
                    if (fail_count <= MAX_SHOWN)
                        $display("mismatch: exp pin=%0d done=%0d dist=%0d err=%0d busy=%0d,%s",
                                 want.pin_drive, want.done_res, want.distance_cm,
                                 want.error_code, want.busy_res,
                                 $sformatf(" got pin=%0d done=%0d dist=%0d err=%0d busy=%0d",
                                           result.pin_drive, result.done_res,
                                           result.distance_cm, result.error_code,
                                           result.busy_res));
                end
            end
        end
    end

    // Send one tick item, with random idle cycles ahead of it unless quiet is set
    task automatic send_tick(input logic start, input logic echo);
        item_t it;
        it.start_request = start;
        it.echo_level    = echo;
        while (!quiet && $urandom_range(0, 99) < 24)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        pending_results.push_back(compute_tick(it));
        ticks_sent++;
    endtask

    // One measurement: start, trigger, echo delay, echo pulse, fall.
    // abort_at puts a second start on that tick (negative: none).
    task automatic ping(input int rise_delay, input int echo_len, input int abort_at);
        int ntrig;
        int total;
        int rise_at;
        ntrig   = (trig_reg == 0) ? 1 : int'(trig_reg);
        rise_at = 1 + ntrig + rise_delay;
        total   = rise_at + echo_len + 2;
        for (int p = 0; p < total; p++)
            send_tick(p == 0 || p == abort_at, p >= rise_at && p < total - 1);
    endtask

    // Let every expected result come back, then the pipeline settle
    task automatic drain();
        item_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            REG_TRIGGER:  trig_reg = data;
            REG_TIMEOUT:  tmo_reg  = data;
            REG_MIN_DIST: min_reg  = data[9:0];
            REG_MAX_DIST: max_reg  = data[9:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_config(input logic [15:0] trig, input logic [15:0] tmo,
                              input logic [15:0] dmin, input logic [15:0] dmax);
        drain();
        write_reg(REG_TRIGGER, trig);
        write_reg(REG_TIMEOUT, tmo);
        write_reg(REG_MIN_DIST, dmin);
        write_reg(REG_MAX_DIST, dmax);
        cfg_write <= 1'b0;
    endtask

    // Reset register values: in range, just below range, zero length echo
    task automatic test_reset_values();
        ping(2, 240, -1);
        ping(0, 200, -1);
        ping(0, 0, -1);
    endtask

    // Edge handling in each phase and starts while busy
    task automatic test_edge_rules();
        set_config(16'd2, 16'd20, 16'd0, 16'd1023);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);      // rise while idle
        send_tick(1'b0, 1'b0);      // fall while idle is harmless
        send_tick(1'b1, 1'b1);      // rise beats start
        send_tick(1'b1, 1'b1);      // level high, no edge: start taken
        send_tick(1'b0, 1'b0);      // edges ignored in trigger
        send_tick(1'b0, 1'b1);      // enters rise wait with echo high
        send_tick(1'b0, 1'b0);      // fall ignored in rise wait
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b0);      // done, distance 0
        // busy start in trigger, rise wait and fall wait
        ping(3, 10, 1);
        ping(3, 10, 4);
        ping(3, 10, 9);
    endtask

    // Zero lengths, zero timeout, inverted and single-value windows
    task automatic test_special_settings();
        set_config(16'd0, 16'd0, 16'd0, 16'd1023);
        ping(0, 0, -1);
        ping(1, 0, -1);
        ping(0, 3, -1);
        set_config(16'd1, 16'd1, 16'd1023, 16'd0);
        ping(0, 0, -1);
        set_config(16'd1, 16'd300, 16'd1, 16'd1);
        ping(0, 150, -1);
        ping(0, 300, -1);
    endtask

    // Full-scale trigger and timeout, busy start during a long trigger,
    // a window that only holds the top distance
    task automatic test_extreme_settings();
        set_config(16'd65535, 16'd65535, 16'd0, 16'd1023);
        send_tick(1'b1, 1'b0);
        repeat (20) send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b1);      // busy start while still triggering
        send_tick(1'b0, 1'b0);
        set_config(16'd1, 16'd65535, 16'd1023, 16'd1023);
        ping(3, 10, -1);
    endtask

    // Mostly well-formed measurements with random timing, some noise
    task automatic test_random_traffic();
        int stop_at;
        int n_ping;
        int r;
        int rd;
        int el;
        int ab;
        int burst;
        logic [15:0] trig;
        logic [15:0] tmo;
        logic [9:0]  dmin;
        logic [9:0]  dmax;
        logic        echo;
        stop_at = ticks_sent + RANDOM_TICKS;
        n_ping  = 0;
        quiet   = 1'b1;
        echo    = 1'b0;
        while (ticks_sent < stop_at)
        begin
            if (quiet && ticks_sent > stop_at - RANDOM_TICKS + QUIET_TICKS)
                quiet = 1'b0;
            if (n_ping % 6 == 0)
            begin
                r    = $urandom_range(0, 99);
                trig = (r < 70) ? 16'($urandom_range(0, 12))
                     : (r < 80) ? 16'd0 : 16'($urandom_range(13, 200));
                r    = $urandom_range(0, 99);
                tmo  = (r < 60) ? 16'd300
                     : (r < 80) ? 16'($urandom_range(0, 30)) : 16'($urandom_range(31, 400));
                dmin = ($urandom_range(0, 9) == 0) ? 10'd1023 : 10'($urandom_range(0, 3));
                dmax = ($urandom_range(0, 9) == 0) ? 10'd1023 : 10'($urandom_range(0, 5));
                // upper data bits are don't-care for the distance registers
                set_config(trig, tmo, {6'($urandom), dmin}, {6'($urandom), dmax});
            end
            n_ping++;
            r = $urandom_range(0, 99);
            if (r < 75)
            begin
                rd = ($urandom_range(0, 4) != 0) ? $urandom_range(0, 6)
                                                 : $urandom_range(0, int'(tmo_reg) + 3);
                r  = $urandom_range(0, 99);
                el = (r < 50) ? $urandom_range(0, 120)
                   : (r < 85) ? $urandom_range(116, 260) : $urandom_range(0, int'(tmo_reg) + 3);
                ab = ($urandom_range(0, 99) < 15) ? $urandom_range(1, 20 + rd + el) : -1;
                ping(rd, el, ab);
                echo = 1'b0;
            end
            else
            begin
                burst = $urandom_range(5, 40);
                repeat (burst)
                begin
                    if ($urandom_range(0, 99) < 30)
                        echo = !echo;
                    send_tick($urandom_range(0, 9) == 0, echo);
                end
            end
        end
        quiet = 1'b0;
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_values();
        test_edge_rules();
        test_special_settings();
        test_extreme_settings();
        test_random_traffic();
        drain();
        if (fail_count == 0)
            $display("ultrasonic_single_pin_ranger test passed");
        else
            $display("ultrasonic_single_pin_ranger test failed");
        $finish;
    end

    initial
    begin
        #(RUN_LIMIT);
        $display("ultrasonic_single_pin_ranger test failed");
        $finish;
    end

endmodule
